>>> design/hdrtm_pkg.sv
// ----------------------------------------------------------------------------
// HDR tone-map pixel package
// Shared widths, register codes and the elaboration-time threshold function
// used to build the tone-curve tables.
// ----------------------------------------------------------------------------
package hdrtm_pkg;

  localparam int TONE_W  = 8;    // tone byte width, one search stage per bit
  localparam int CFG_W   = 13;   // configuration register width
  localparam int POS_W   = 12;   // pixel coordinate width
  localparam int ADDR_W  = 26;   // byte address width
  localparam int THR_W   = 41;   // widest channel (40 bits) plus one
  localparam int BIG_W   = 320;  // room for 255^11 * D^5 at the widest channel
  localparam int TONE_MAX  = 255;
  localparam int GAMMA_NUM = 11; // 2.2 = 11/5
  localparam int GAMMA_DEN = 5;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd800;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd600;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [BIG_W-1:0] big_t;

  function automatic big_t big_pow(big_t base, int e);
    big_t r;
    r = big_t'(1);
    for (int i = 0; i < e; i++) begin
      r = r * base;
    end
    return r;
  endfunction

  // Smallest channel code C for which the tone byte reaches k. The test
  // 255^11 * D^5 >= k^11 * (D + 2^(F+1))^5 with D = 2C+1 is exact, so the
  // table matches the rounded thresholds bit for bit. Code 255 is never
  // reached and gets a threshold one above the largest channel code.
  function automatic logic [THR_W-1:0] tone_threshold(int k, int frac_bits, int chan_bits);
    logic [THR_W-1:0] lo;
    logic [THR_W-1:0] hi;
    logic [THR_W-1:0] mid;
    big_t             top_pow;
    big_t             k_pow;
    big_t             step;
    big_t             d;
    if (k == 0) begin
      return '0;
    end
    if (k >= TONE_MAX) begin
      return THR_W'(1) << chan_bits;
    end
    top_pow = big_pow(big_t'(TONE_MAX), GAMMA_NUM);
    k_pow   = big_pow(big_t'(k), GAMMA_NUM);
    step    = big_t'(1) << (frac_bits + 1);
    lo      = '0;
    hi      = THR_W'(1) << chan_bits;
    while (lo < hi) begin
      // The sum is taken one bit wider so that it cannot wrap.
      mid = THR_W'(({1'b0, lo} + {1'b0, hi}) >> 1);
      d   = (big_t'(mid) << 1) + big_t'(1);
      if (top_pow * big_pow(d, GAMMA_DEN) >= k_pow * big_pow(d + step, GAMMA_DEN)) begin
        hi = mid;
      end else begin
        lo = mid + THR_W'(1);
      end
    end
    return hi;
  endfunction

endpackage

>>> design/hdrtm_pix_if.sv
// ----------------------------------------------------------------------------
// HDR pixel input channel
// Valid/ready channel carrying one HDR pixel item: position and three colors.
// ----------------------------------------------------------------------------
interface hdrtm_pix_if
  import hdrtm_pkg::*;
#(
  parameter int CHAN_W = 24
);
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic [CHAN_W-1:0] red_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] blue_in;

  modport source (output valid, pos_x, pos_y, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, pos_x, pos_y, red_in, green_in, blue_in, output ready);
endinterface

>>> design/hdrtm_res_if.sv
// ----------------------------------------------------------------------------
// Tone-mapped pixel output channel
// Valid/ready channel carrying one framebuffer write item.
// ----------------------------------------------------------------------------
interface hdrtm_res_if
  import hdrtm_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] byte_address;
  logic [TONE_W-1:0] red_out;
  logic [TONE_W-1:0] green_out;
  logic [TONE_W-1:0] blue_out;
  logic              out_of_frame;

  modport source (output valid, byte_address, red_out, green_out, blue_out, out_of_frame,
                  input ready);
  modport sink   (input valid, byte_address, red_out, green_out, blue_out, out_of_frame,
                  output ready);
endinterface

>>> design/hdrtm_lane.sv
// ----------------------------------------------------------------------------
// Tone-map lane
// Eight-stage bitwise search of the tone-curve threshold table for one channel.
// ----------------------------------------------------------------------------
module hdrtm_lane
  import hdrtm_pkg::*;
#(
  parameter int CHAN_W = 24,
  parameter int FRAC_W = 16
) (
  input  logic              clk_i,
  input  logic [TONE_W-1:0] en_i,
  input  logic [CHAN_W-1:0] chan_i,
  output logic [TONE_W-1:0] tone_o
);

  logic [CHAN_W:0]   thr [2**TONE_W];
  logic [CHAN_W-1:0] c_q [TONE_W-1];
  logic [TONE_W-1:0] k_q [TONE_W];

  for (genvar k = 0; k < 2**TONE_W; k++) begin : g_thr
    localparam logic [THR_W-1:0] Thr = tone_threshold(k, FRAC_W, CHAN_W);
    assign thr[k] = Thr[CHAN_W:0];
  end

  // Stage s decides bit (TONE_W-1-s) of the byte; thresholds rise with k.
  for (genvar s = 0; s < TONE_W; s++) begin : g_stage
    logic [CHAN_W-1:0] c_in;
    logic [TONE_W-1:0] k_in;
    logic [TONE_W-1:0] cand;

    if (s == 0) begin : g_first
      assign c_in = chan_i;
      assign k_in = '0;
    end else begin : g_next
      assign c_in = c_q[s-1];
      assign k_in = k_q[s-1];
    end

    assign cand = k_in | (TONE_W'(1) << (TONE_W - 1 - s));

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        k_q[s] <= ({1'b0, c_in} >= thr[cand]) ? cand : k_in;
      end
    end

    if (s < TONE_W - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i[s]) begin
          c_q[s] <= c_in;
        end
      end
    end
  end

  assign tone_o = k_q[TONE_W-1];

endmodule

>>> design/hdrtm_addr.sv
// ----------------------------------------------------------------------------
// Framebuffer address lane
// Bounds check and bottom-up RGBA byte address, delayed to match the tone lanes.
// ----------------------------------------------------------------------------
module hdrtm_addr
  import hdrtm_pkg::*;
(
  input  logic              clk_i,
  input  logic [TONE_W-1:0] en_i,
  input  logic [CFG_W-1:0]  frame_width_i,
  input  logic [CFG_W-1:0]  frame_height_i,
  input  logic [POS_W-1:0]  pos_x_i,
  input  logic [POS_W-1:0]  pos_y_i,
  output logic [ADDR_W-1:0] byte_address_o,
  output logic              out_of_frame_o
);

  logic [CFG_W-1:0]   rows_q;
  logic [POS_W-1:0]   x0_q;
  logic               oof0_q;
  logic [ADDR_W-1:0]  prod_q;
  logic [POS_W-1:0]   x1_q;
  logic               oof1_q;
  logic [2*CFG_W-1:0] prod_full;
  logic [ADDR_W-1:0]  pix_sum;
  logic [ADDR_W-1:0]  addr_q [2:TONE_W-1];
  logic               oof_q  [2:TONE_W-1];

  // Stage 0: flipped row index and the bounds check.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rows_q <= frame_height_i - CFG_W'(1) - {1'b0, pos_y_i};
      x0_q   <= pos_x_i;
      oof0_q <= ({1'b0, pos_x_i} >= frame_width_i) || ({1'b0, pos_y_i} >= frame_height_i);
    end
  end

  // Stage 1: row times width.
  assign prod_full = rows_q * frame_width_i;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      prod_q <= ADDR_W'(prod_full);
      x1_q   <= x0_q;
      oof1_q <= oof0_q;
    end
  end

  // Stage 2: add the column and scale to bytes.
  assign pix_sum = prod_q + ADDR_W'(x1_q);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      addr_q[2] <= oof1_q ? '0 : {pix_sum[ADDR_W-3:0], 2'b00};
      oof_q[2]  <= oof1_q;
    end
  end

  for (genvar s = 3; s < TONE_W; s++) begin : g_delay
    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        addr_q[s] <= addr_q[s-1];
        oof_q[s]  <= oof_q[s-1];
      end
    end
  end

  assign byte_address_o = addr_q[TONE_W-1];
  assign out_of_frame_o = oof_q[TONE_W-1];

endmodule

>>> design/hdr_tone_map_pixel_core.sv
// ----------------------------------------------------------------------------
// HDR tone-map pixel core
// Reinhard tone mapping with gamma 2.2 on three color lanes, plus the byte
// address of the pixel in a bottom-up RGBA framebuffer.
// ----------------------------------------------------------------------------
// The core takes one pixel item per clock while the output side is not
// stalled and returns one result item per pixel, in order, through the lane
// stages and the output register. Each of the red, green and blue lanes runs an
// eight-stage pipelined search over a constant table of tone-curve
// thresholds, one table read and one compare per stage, so the pipeline depth is set
// by the eight bits of the output byte plus the output register. An address
// lane computes the flipped framebuffer offset with one multiplier in step
// with the color lanes, and the output register merges all four lanes into
// the result item. Every stage has its own valid bit and advances when the
// stage after it is empty or moving, so bubbles are squeezed out and input
// ready drops only when all nine stages hold items. Frame width and height
// are written through the plain configuration port (values above MAX_DIM
// saturate) and must only be changed while the core holds no items.
// ----------------------------------------------------------------------------
module hdr_tone_map_pixel_core
  import hdrtm_pkg::*;
#(
  parameter int COLOR_FRAC_BITS = 16,
  parameter int COLOR_INT_BITS  = 8,
  parameter int MAX_DIM         = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  hdrtm_pix_if.sink        pix_i,
  hdrtm_res_if.source      res_o
);

  localparam int ChanW  = COLOR_INT_BITS + COLOR_FRAC_BITS;
  localparam int Stages = TONE_W + 1;

  logic [CFG_W-1:0]  frame_width_q;
  logic [CFG_W-1:0]  frame_height_q;
  logic [CFG_W-1:0]  cfg_sat;
  logic [Stages-1:0] stage_v_q;
  logic [Stages-1:0] stage_v_d;
  logic [Stages-1:0] stage_en;
  logic [TONE_W-1:0] red_tone;
  logic [TONE_W-1:0] green_tone;
  logic [TONE_W-1:0] blue_tone;
  logic [ADDR_W-1:0] lane_addr;
  logic              lane_oof;
  logic [ADDR_W-1:0] byte_address_q;
  logic [TONE_W-1:0] red_q;
  logic [TONE_W-1:0] green_q;
  logic [TONE_W-1:0] blue_q;
  logic              oof_q;

  // Configuration: writes saturate to the largest supported frame size.
  assign cfg_sat = (32'(cfg_data_i) > 32'(MAX_DIM)) ? CFG_W'(MAX_DIM) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_sat;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_sat;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its successor loads.
  always_comb begin
    stage_en[Stages-1] = !stage_v_q[Stages-1] || res_o.ready;
    for (int s = Stages - 2; s >= 0; s--) begin
      stage_en[s] = !stage_v_q[s] || stage_en[s+1];
    end
  end

  always_comb begin
    stage_v_d[0] = stage_en[0] ? pix_i.valid : stage_v_q[0];
    for (int s = 1; s < Stages; s++) begin
      stage_v_d[s] = stage_en[s] ? stage_v_q[s-1] : stage_v_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= '0;
    end else begin
      stage_v_q <= stage_v_d;
    end
  end

  assign pix_i.ready = stage_en[0];

  hdrtm_lane #(.CHAN_W(ChanW), .FRAC_W(COLOR_FRAC_BITS)) u_lane_red (
    .clk_i  (clk_i),
    .en_i   (stage_en[TONE_W-1:0]),
    .chan_i (pix_i.red_in),
    .tone_o (red_tone)
  );

  hdrtm_lane #(.CHAN_W(ChanW), .FRAC_W(COLOR_FRAC_BITS)) u_lane_green (
    .clk_i  (clk_i),
    .en_i   (stage_en[TONE_W-1:0]),
    .chan_i (pix_i.green_in),
    .tone_o (green_tone)
  );

  hdrtm_lane #(.CHAN_W(ChanW), .FRAC_W(COLOR_FRAC_BITS)) u_lane_blue (
    .clk_i  (clk_i),
    .en_i   (stage_en[TONE_W-1:0]),
    .chan_i (pix_i.blue_in),
    .tone_o (blue_tone)
  );

  hdrtm_addr u_addr (
    .clk_i          (clk_i),
    .en_i           (stage_en[TONE_W-1:0]),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .pos_x_i        (pix_i.pos_x),
    .pos_y_i        (pix_i.pos_y),
    .byte_address_o (lane_addr),
    .out_of_frame_o (lane_oof)
  );

  // Merge stage: the output register gathers all four lanes into one item.
  always_ff @(posedge clk_i) begin
    if (stage_en[Stages-1]) begin
      byte_address_q <= lane_addr;
      red_q          <= red_tone;
      green_q        <= green_tone;
      blue_q         <= blue_tone;
      oof_q          <= lane_oof;
    end
  end

  assign res_o.valid        = stage_v_q[Stages-1];
  assign res_o.byte_address = byte_address_q;
  assign res_o.red_out      = red_q;
  assign res_o.green_out    = green_q;
  assign res_o.blue_out     = blue_q;
  assign res_o.out_of_frame = oof_q;

`ifndef SYNTHESIS
  // Input is held off only when every stage holds an item.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> &stage_v_q)
    else $error("input stalled while the pipeline has a free stage");

  // The top code of the tone curve is never reached.
  a_tone_below_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.red_out != 8'hFF) && (res_o.green_out != 8'hFF) &&
                    (res_o.blue_out != 8'hFF))
    else $error("tone byte reached the unreachable top code");

  // A pixel outside the frame carries a zero address.
  a_oof_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.out_of_frame |-> res_o.byte_address == '0)
    else $error("out-of-frame pixel carries a nonzero address");
`endif

endmodule
